@@ hdl/tep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_pkg
// Widths, codes and the node record shared by the tree ensemble predictor.
// ----------------------------------------------------------------------------
package tep_pkg;

   localparam int MODE_W       = 2;
   localparam int NODE_ADDR_W  = 10;
   localparam int TREE_IDX_W   = 7;
   localparam int FEAT_SEL_W   = 2;
   localparam int THR_W        = 21;
   localparam int VALUE_W      = 48;
   localparam int FEAT_W       = 20;
   localparam int PRED_W       = 47;
   localparam int COUNT_W      = 8;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 48;

   localparam logic [MODE_W-1:0] MODE_WRITE_NODE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_ROOT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

   localparam logic [FEAT_SEL_W-1:0] FEAT_LIN  = 2'd0;
   localparam logic [FEAT_SEL_W-1:0] FEAT_LOUT = 2'd1;
   localparam logic [FEAT_SEL_W-1:0] FEAT_BS   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BASE_VALUE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TREE_COUNT = 1'd1;

   localparam logic [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic                   leaf;
      logic [FEAT_SEL_W-1:0]  feat;
      logic [THR_W-1:0]       thr;
      logic [NODE_ADDR_W-1:0] left;
      logic [NODE_ADDR_W-1:0] right;
      logic [VALUE_W-1:0]     value;
   } node_type;

endpackage

@@ hdl/tep_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_req_if
// Request channel: node writes, root writes and queries.
// ----------------------------------------------------------------------------
interface tep_req_if;
   import tep_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MODE_W-1:0]      mode;
   logic [NODE_ADDR_W-1:0] node_addr;
   logic [TREE_IDX_W-1:0]  tree_index;
   logic                   node_is_leaf;
   logic [FEAT_SEL_W-1:0]  node_feature;
   logic signed [THR_W-1:0]   node_threshold;
   logic [NODE_ADDR_W-1:0] node_left;
   logic [NODE_ADDR_W-1:0] node_right;
   logic signed [VALUE_W-1:0] node_value;
   logic [FEAT_W-1:0]      feat_lin;
   logic [FEAT_W-1:0]      feat_lout;
   logic [FEAT_W-1:0]      feat_bs;

   modport source (
      output valid, mode, node_addr, tree_index, node_is_leaf, node_feature,
             node_threshold, node_left, node_right, node_value,
             feat_lin, feat_lout, feat_bs,
      input  ready
   );

   modport sink (
      input  valid, mode, node_addr, tree_index, node_is_leaf, node_feature,
             node_threshold, node_left, node_right, node_value,
             feat_lin, feat_lout, feat_bs,
      output ready
   );

endinterface

@@ hdl/tep_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_rsp_if
// Result channel: one beat per query.
// ----------------------------------------------------------------------------
interface tep_rsp_if;
   import tep_pkg::*;

   logic              valid;
   logic              ready;
   logic [PRED_W-1:0] prediction;
   logic              was_clamped;
   logic              walk_overrun;

   modport source (
      output valid, prediction, was_clamped, walk_overrun,
      input  ready
   );

   modport sink (
      input  valid, prediction, was_clamped, walk_overrun,
      output ready
   );

endinterface

@@ hdl/tep_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tree_ensemble_predictor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_ensemble_predictor
// Decision-tree ensemble inference over a node RAM and a root RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one beat per command. Mode 0 writes a node record, mode
//   1 writes a tree root address, mode 2 runs a query on three features.
//   Mode 0, mode 1 and unused codes give no result beat.
//   A query walks trees 0 .. min(tree_count, MAX_TREES)-1 in order, one RAM
//   read per cycle: a root lookup for each tree, then a read for each node
//   visited. A walk stops at MAX_WALK nodes.
//   rsp_port gives one beat per query: the clamped sum and two flags.
//   csr_* writes base_value (index 0) or tree_count (index 1); the user
//   writes them only while idle, which the block itself does not enforce.
//   Reset clears the control state, base_value and tree_count; the node and
//   root RAMs hold nothing defined until written.
//   req_port.ready is high only between commands. A finished result waits
//   in the output register while rsp_port is stalled; node and root writes
//   are still taken then, and a new query stalls only at its own finish.
// ----------------------------------------------------------------------------
module tree_ensemble_predictor #(
   parameter int NODE_DEPTH = 1024,
   parameter int MAX_TREES  = 128,
   parameter int MAX_WALK   = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   tep_req_if.sink                      req_port,
   tep_rsp_if.source                    rsp_port,
   input  logic                         csr_wr_en,
   input  logic [tep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tep_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import tep_pkg::*;

   localparam int NODE_AW  = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam int TREE_AW  = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
   localparam int TREE_CW  = $clog2(MAX_TREES + 1);
   localparam int VISIT_W  = $clog2(MAX_WALK);
   localparam int NODE_W   = $bits(node_type);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_NODE = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]         state_ff,   state_in;
   logic [TREE_CW-1:0] tree_ff,    tree_in;
   logic [TREE_CW-1:0] trees_ff,   trees_in;
   logic [VISIT_W-1:0] visit_ff,   visit_in;
   logic [VALUE_W-1:0] sum_ff,     sum_in;
   logic               overrun_ff, overrun_in;
   logic [FEAT_W-1:0]  lin_ff,     lin_in;
   logic [FEAT_W-1:0]  lout_ff,    lout_in;
   logic [FEAT_W-1:0]  bs_ff,      bs_in;
   logic [VALUE_W-1:0] base_ff,    base_in;
   logic [COUNT_W-1:0] count_ff,   count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRED_W-1:0]  pred_ff,    pred_in;
   logic               clamped_ff, clamped_in;
   logic               ovr_out_ff, ovr_out_in;

   logic               node_wr_en;
   logic [NODE_AW-1:0] node_wr_addr;
   node_type           node_wr_data;
   logic               node_rd_en;
   logic [NODE_AW-1:0] node_rd_addr;
   logic [NODE_W-1:0]  node_rd_raw;
   node_type           node_q;

   logic                   root_wr_en;
   logic [TREE_AW-1:0]     root_wr_addr;
   logic                   root_rd_en;
   logic [TREE_AW-1:0]     root_rd_addr;
   logic [NODE_ADDR_W-1:0] root_q;

   logic               req_fire;
   logic               rsp_fire;
   logic [FEAT_W-1:0]  feat_val;
   logic               go_left;
   logic [NODE_ADDR_W-1:0] child;
   logic signed [VALUE_W:0] sum_wide;
   logic [VALUE_W-1:0] sum_sat;
   logic               next_tree;
   logic [TREE_CW-1:0] tree_next;

   tep_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH), .AW(NODE_AW)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_data),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_raw)
   );

   tep_ram #(.WIDTH(NODE_ADDR_W), .DEPTH(MAX_TREES), .AW(TREE_AW)) u_root_ram (
      .clock   (clock),
      .wr_en   (root_wr_en),
      .wr_addr (root_wr_addr),
      .wr_data (req_port.node_addr),
      .rd_en   (root_rd_en),
      .rd_addr (root_rd_addr),
      .rd_data (root_q)
   );

   assign node_q   = node_type'(node_rd_raw);
   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire = req_port.valid && req_port.ready;
   assign rsp_fire = rsp_valid_ff && rsp_port.ready;

   assign node_wr_addr = NODE_AW'(req_port.node_addr);
   assign root_wr_addr = TREE_AW'(req_port.tree_index);
   assign node_wr_en   = req_fire && (req_port.mode == MODE_WRITE_NODE)
                         && (32'(req_port.node_addr) < NODE_DEPTH);
   assign root_wr_en   = req_fire && (req_port.mode == MODE_WRITE_ROOT)
                         && (32'(req_port.tree_index) < MAX_TREES);

   always_comb begin
      node_wr_data.leaf  = req_port.node_is_leaf;
      node_wr_data.feat  = req_port.node_feature;
      node_wr_data.thr   = req_port.node_threshold;
      node_wr_data.left  = req_port.node_left;
      node_wr_data.right = req_port.node_right;
      node_wr_data.value = req_port.node_value;
   end

   always_comb begin
      case (node_q.feat)
         FEAT_LIN:  feat_val = lin_ff;
         FEAT_LOUT: feat_val = lout_ff;
         FEAT_BS:   feat_val = bs_ff;
         default:   feat_val = '0;
      endcase
   end

   assign go_left  = $signed({2'b00, feat_val}) <= $signed({node_q.thr[THR_W-1], node_q.thr});
   assign child    = go_left ? node_q.left : node_q.right;
   assign sum_wide = $signed({sum_ff[VALUE_W-1], sum_ff})
                     + $signed({node_q.value[VALUE_W-1], node_q.value});
   assign sum_sat  = (sum_wide[VALUE_W] != sum_wide[VALUE_W-1])
                     ? (sum_wide[VALUE_W] ? SUM_MIN : SUM_MAX)
                     : sum_wide[VALUE_W-1:0];
   assign tree_next = tree_ff + TREE_CW'(1);

   always_comb begin
      state_in     = state_ff;
      tree_in      = tree_ff;
      trees_in     = trees_ff;
      visit_in     = visit_ff;
      sum_in       = sum_ff;
      overrun_in   = overrun_ff;
      lin_in       = lin_ff;
      lout_in      = lout_ff;
      bs_in        = bs_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      pred_in      = pred_ff;
      clamped_in   = clamped_ff;
      ovr_out_in   = ovr_out_ff;
      root_rd_en   = 1'b0;
      root_rd_addr = '0;
      node_rd_en   = 1'b0;
      node_rd_addr = '0;
      next_tree    = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            REG_BASE_VALUE: base_in  = csr_wr_data[VALUE_W-1:0];
            REG_TREE_COUNT: count_in = csr_wr_data[COUNT_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_port.mode == MODE_QUERY)) begin
               lin_in     = req_port.feat_lin;
               lout_in    = req_port.feat_lout;
               bs_in      = req_port.feat_bs;
               sum_in     = base_ff;
               overrun_in = 1'b0;
               tree_in    = '0;
               trees_in   = (32'(count_ff) > MAX_TREES) ? TREE_CW'(MAX_TREES)
                                                        : TREE_CW'(count_ff);
               if (count_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  root_rd_en   = 1'b1;
                  root_rd_addr = '0;
                  state_in     = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (32'(root_q) < NODE_DEPTH) begin
               node_rd_en   = 1'b1;
               node_rd_addr = NODE_AW'(root_q);
               visit_in     = '0;
               state_in     = ST_NODE;
            end else begin
               overrun_in = 1'b1;
               next_tree  = 1'b1;
            end
         end
         ST_NODE: begin
            if (node_q.leaf) begin
               sum_in    = sum_sat;
               next_tree = 1'b1;
            end else if (visit_ff == VISIT_W'(MAX_WALK - 1)
                         || !(32'(child) < NODE_DEPTH)) begin
               overrun_in = 1'b1;
               next_tree  = 1'b1;
            end else begin
               node_rd_en   = 1'b1;
               node_rd_addr = NODE_AW'(child);
               visit_in     = visit_ff + VISIT_W'(1);
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               clamped_in   = sum_ff[VALUE_W-1];
               pred_in      = sum_ff[VALUE_W-1] ? '0 : sum_ff[PRED_W-1:0];
               ovr_out_in   = overrun_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (next_tree) begin
         if (tree_next == trees_ff) begin
            state_in = ST_FIN;
         end else begin
            tree_in      = tree_next;
            root_rd_en   = 1'b1;
            root_rd_addr = TREE_AW'(tree_next);
            state_in     = ST_ROOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tree_ff      <= '0;
         trees_ff     <= '0;
         visit_ff     <= '0;
         sum_ff       <= '0;
         overrun_ff   <= 1'b0;
         base_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tree_ff      <= tree_in;
         trees_ff     <= trees_in;
         visit_ff     <= visit_in;
         sum_ff       <= sum_in;
         overrun_ff   <= overrun_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lin_ff     <= lin_in;
      lout_ff    <= lout_in;
      bs_ff      <= bs_in;
      pred_ff    <= pred_in;
      clamped_ff <= clamped_in;
      ovr_out_ff <= ovr_out_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.prediction   = pred_ff;
   assign rsp_port.was_clamped  = clamped_ff;
   assign rsp_port.walk_overrun = ovr_out_ff;

   a_walk_tree_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT || state_ff == ST_NODE) |-> (tree_ff < trees_ff))
      else $error("tree counter beyond tree limit during walk");

   a_walk_depth_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NODE) |-> (32'(visit_ff) < MAX_WALK))
      else $error("walk visit counter beyond depth limit");

   a_clamp_gives_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && clamped_ff) |-> (pred_ff == '0))
      else $error("clamped result with nonzero prediction");

   a_query_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_port.mode == MODE_QUERY) |=> (state_ff != ST_IDLE))
      else $error("query accepted without starting a walk");

   a_single_ram_read : assert property (@(posedge clock) disable iff (reset)
      !(root_rd_en && node_rd_en))
      else $error("root and node reads issued in the same cycle");

endmodule
